@@ rtl/core/pns_pkg.sv @@
// Shared constants and the front-to-back queue entry type of the path normalizer.
package pns_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned MAX_RAW = 3;   // most bytes one item can release from the matcher
  localparam int unsigned RAW_CNT_W = $clog2(MAX_RAW + 1);
  localparam int unsigned RAW_IDX_W = $clog2(MAX_RAW);

  // queue depth, power of two so the pointers wrap by themselves
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_SLASH     = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_DOT       = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_LOWER_C   = 8'h63;
  localparam logic [CHAR_W-1:0] CH_COLON     = 8'h3A;

  // bytes released by the matcher for one item, before slash collapse
  typedef struct packed {
    logic [MAX_RAW-1:0][CHAR_W-1:0] bytes;
    logic [RAW_CNT_W-1:0]           cnt;
    logic                           last;
  } raw_entry_t;

endpackage

@@ rtl/core/pns_front.sv @@
// Front end: backslash fold and "c:/" matcher, one item per cycle into the queue while it is not full.
module pns_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [pns_pkg::CHAR_W-1:0]  in_char,
  input  logic                        in_last,
  input  logic                        q_full,
  output logic                        push,
  output pns_pkg::raw_entry_t         push_entry
);
  import pns_pkg::*;

  typedef enum logic [1:0] {M_IDLE, M_C, M_CCOLON} match_t;

  match_t            st_r, st_nxt;
  logic [CHAR_W-1:0] ch;
  logic              accept;
  raw_entry_t        ent;

  always_comb begin
    ch     = (in_char == CH_BACKSLASH) ? CH_SLASH : in_char;
    ent    = '0;
    st_nxt = st_r;
    unique case (st_r)
      M_IDLE: begin
        if (ch == CH_LOWER_C) begin
          st_nxt = M_C;
          if (in_last) begin
            ent.bytes[0] = CH_LOWER_C;
            ent.cnt      = RAW_CNT_W'(1);
          end
        end else begin
          ent.bytes[0] = ch;
          ent.cnt      = RAW_CNT_W'(1);
        end
      end
      M_C: begin
        if (ch == CH_COLON) begin
          st_nxt = M_CCOLON;
          if (in_last) begin
            ent.bytes[0] = CH_LOWER_C;
            ent.bytes[1] = CH_COLON;
            ent.cnt      = RAW_CNT_W'(2);
          end
        end else if (ch == CH_LOWER_C) begin
          // the older c goes out, the new one stays pending
          ent.bytes[0] = CH_LOWER_C;
          ent.bytes[1] = CH_LOWER_C;
          ent.cnt      = in_last ? RAW_CNT_W'(2) : RAW_CNT_W'(1);
        end else begin
          st_nxt       = M_IDLE;
          ent.bytes[0] = CH_LOWER_C;
          ent.bytes[1] = ch;
          ent.cnt      = RAW_CNT_W'(2);
        end
      end
      M_CCOLON: begin
        if (ch == CH_SLASH) begin
          st_nxt       = M_IDLE;
          ent.bytes[0] = CH_SLASH;
          ent.cnt      = RAW_CNT_W'(1);
        end else if (ch == CH_LOWER_C) begin
          st_nxt       = M_C;
          ent.bytes[0] = CH_LOWER_C;
          ent.bytes[1] = CH_COLON;
          ent.bytes[2] = CH_LOWER_C;
          ent.cnt      = in_last ? RAW_CNT_W'(3) : RAW_CNT_W'(2);
        end else begin
          st_nxt       = M_IDLE;
          ent.bytes[0] = CH_LOWER_C;
          ent.bytes[1] = CH_COLON;
          ent.bytes[2] = ch;
          ent.cnt      = RAW_CNT_W'(3);
        end
      end
      default: st_nxt = M_IDLE;
    endcase
    ent.last = in_last;
    if (in_last) begin
      st_nxt = M_IDLE;
    end
  end

  assign in_ready   = !q_full;
  assign accept     = in_valid && !q_full;
  assign push       = accept && ((ent.cnt != '0) || in_last);
  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= M_IDLE;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

`ifndef SYNTHESIS
  a_end_clears_match: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last) |=> (st_r == M_IDLE))
    else $error("matcher not idle after end of path");
  a_last_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_entry.last) |-> (push_entry.cnt != '0))
    else $error("end-of-path entry carries no byte");
  a_idle_item_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (st_r != M_IDLE) && (ch != CH_COLON) && (ch != CH_LOWER_C)) |-> push)
    else $error("pending match dropped without flush");
`endif

endmodule

@@ rtl/core/pns_queue.sv @@
// Short register queue between the matcher front end and the emit back end.
module pns_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  pns_pkg::raw_entry_t  push_entry,
  input  logic                 pop,
  output pns_pkg::raw_entry_t  head,
  output logic                 empty,
  output logic                 full
);
  import pns_pkg::*;

  raw_entry_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("queue underflow");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (QPTR_W'(wr_ptr_r - rd_ptr_r) == QPTR_W'(cnt_r)))
    else $error("queue pointers and count disagree");
`endif

endmodule

@@ rtl/core/pns_back.sv @@
// Back end: slash collapse, "./" prefix and the registered result stage.
module pns_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  pns_pkg::raw_entry_t         head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pns_pkg::CHAR_W-1:0]  out_char,
  output logic                        out_present,
  output logic                        out_final
);
  import pns_pkg::*;

  typedef enum logic [1:0] {PFX_NONE, PFX_DOT, PFX_SLASH} pfx_t;

  pfx_t                 pfx_r, pfx_nxt;
  logic [RAW_IDX_W-1:0] idx_r, idx_nxt;
  logic                 emitted_any_r, emitted_any_nxt;
  logic                 last_slash_r, last_slash_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]    out_char_r, out_char_nxt;
  logic                 out_present_r, out_present_nxt;
  logic                 out_final_r, out_final_nxt;

  logic              adv;
  logic [CHAR_W-1:0] b;
  logic              final_byte, collapse, need_pfx, step_done;

  assign adv        = !q_empty && (!out_valid_r || out_ready);
  assign b          = head.bytes[idx_r];
  assign final_byte = (head.cnt == '0) || (RAW_CNT_W'(idx_r) == head.cnt - RAW_CNT_W'(1));
  assign collapse   = (b == CH_SLASH) && last_slash_r;
  assign need_pfx   = !emitted_any_r && (b != CH_DOT) && (b != CH_SLASH);

  always_comb begin
    pfx_nxt         = pfx_r;
    idx_nxt         = idx_r;
    emitted_any_nxt = emitted_any_r;
    last_slash_nxt  = last_slash_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_char_nxt    = out_char_r;
    out_present_nxt = out_present_r;
    out_final_nxt   = out_final_r;
    step_done       = 1'b0;
    if (adv) begin
      if (head.cnt == '0) begin
        // bare end of path with nothing released
        step_done = 1'b1;
        if (head.last) begin
          out_valid_nxt   = 1'b1;
          out_char_nxt    = '0;
          out_present_nxt = 1'b0;
          out_final_nxt   = 1'b1;
        end
      end else if (need_pfx && (pfx_r != PFX_SLASH)) begin
        out_valid_nxt   = 1'b1;
        out_present_nxt = 1'b1;
        out_final_nxt   = 1'b0;
        if (pfx_r == PFX_NONE) begin
          out_char_nxt = CH_DOT;
          pfx_nxt      = PFX_DOT;
        end else begin
          out_char_nxt = CH_SLASH;
          pfx_nxt      = PFX_SLASH;
        end
      end else if (collapse) begin
        // a collapsed slash is only ever the sole byte of its item
        step_done = final_byte;
        if (final_byte && head.last) begin
          out_valid_nxt   = 1'b1;
          out_char_nxt    = '0;
          out_present_nxt = 1'b0;
          out_final_nxt   = 1'b1;
        end
      end else begin
        step_done       = final_byte;
        out_valid_nxt   = 1'b1;
        out_char_nxt    = b;
        out_present_nxt = 1'b1;
        out_final_nxt   = final_byte && head.last;
        emitted_any_nxt = 1'b1;
        last_slash_nxt  = (b == CH_SLASH);
        pfx_nxt         = PFX_NONE;
      end
      if (step_done) begin
        idx_nxt = '0;
        if (head.last) begin
          emitted_any_nxt = 1'b0;
          last_slash_nxt  = 1'b0;
          pfx_nxt         = PFX_NONE;
        end
      end else if (!(need_pfx && (pfx_r != PFX_SLASH))) begin
        idx_nxt = idx_r + RAW_IDX_W'(1);
      end
    end
  end

  assign pop         = adv && step_done;
  assign out_valid   = out_valid_r;
  assign out_char    = out_char_r;
  assign out_present = out_present_r;
  assign out_final   = out_final_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pfx_r         <= PFX_NONE;
      idx_r         <= '0;
      emitted_any_r <= 1'b0;
      last_slash_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      pfx_r         <= pfx_nxt;
      idx_r         <= idx_nxt;
      emitted_any_r <= emitted_any_nxt;
      last_slash_r  <= last_slash_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    out_char_r    <= out_char_nxt;
    out_present_r <= out_present_nxt;
    out_final_r   <= out_final_nxt;
  end

`ifndef SYNTHESIS
  a_marker_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_present_r) |-> (out_final_r && (out_char_r == '0)))
    else $error("end marker without final flag or with data");
  a_final_resets_path: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && step_done && head.last) |=> (!emitted_any_r && !last_slash_r && idx_r == '0))
    else $error("path state not cleared after end of path");
  a_no_double_slash: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && out_valid_nxt && out_present_nxt && (out_char_nxt == CH_SLASH)
     && (pfx_r == PFX_NONE) && !(need_pfx)) |-> !last_slash_r)
    else $error("slash emitted after slash");
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_empty && head.cnt != '0) |-> (RAW_CNT_W'(idx_r) < head.cnt))
    else $error("byte index beyond entry");
`endif

endmodule

@@ rtl/core/path_normalizer_stream_unit.sv @@
// Top level of the streaming path normalizer.
// Throughput: one input item per cycle while each item releases at most one byte
//   and out_tready stays high; the back end emits at most one result per cycle, so
//   extra "c:" flush bytes and the "./" prefix fill a 4-entry queue before input stalls.
// Reset: synchronous active-low rst_n clears matcher, queue and path state; results drop.
module path_normalizer_stream_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] in_char
  input  logic                        in_tlast,   // end_of_path
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,  // [7:0] out_char
  output logic                        out_tuser,  // [0] char_present
  output logic                        out_tlast   // final_result
);
  import pns_pkg::*;

  logic       q_push, q_pop, q_empty, q_full;
  raw_entry_t q_in, q_head;

  pns_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_char    (in_tdata),
    .in_last    (in_tlast),
    .q_full     (q_full),
    .push       (q_push),
    .push_entry (q_in)
  );

  pns_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty),
    .full       (q_full)
  );

  pns_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .head        (q_head),
    .pop         (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_char    (out_tdata),
    .out_present (out_tuser),
    .out_final   (out_tlast)
  );

endmodule
